/* rtl/plrot_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plrot_pkg: shared types and constants for the plane rotation block
// Widths of the CORDIC and combine datapaths, the arctangent table and the
// words handed between the pipeline sections.
// ----------------------------------------------------------------------------
package plrot_pkg;

	// Configuration of the datapath.
	localparam int CORDIC_STAGES = 16;
	localparam int COORD_WIDTH   = 32;

	// CORDIC formats: x and y in Q2.30, z in units of 2^-22 degree.
	localparam int TRIG_FRAC = 30;
	localparam int TRIG_W    = 32;
	localparam int Z_W       = 32;
	localparam int SH_W      = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
	localparam int ANG_IN_W  = 16;
	localparam int ANG_W     = ANG_IN_W + 1;
	localparam int Z_SHIFT   = 16;

	// Combine datapath: differences are split at bit LO_W into a signed high
	// part and an unsigned low part so each product stays narrow.
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int LO_W   = 24;
	localparam int EXT_W  = (DIFF_W > LO_W + 1) ? DIFF_W : LO_W + 1;
	localparam int HI_W   = EXT_W - LO_W;
	localparam int HP_W   = HI_W + TRIG_W;
	localparam int LP_W   = LO_W + 1 + TRIG_W;
	localparam int HS_W   = HP_W + 1;
	localparam int LS_W   = LP_W + 2;
	localparam int CY_W   = LS_W - LO_W;
	localparam int T_W    = ((HS_W > CY_W) ? HS_W : CY_W) + 1;
	localparam int R_W    = T_W - (TRIG_FRAC - LO_W);
	localparam int V_W    = ((R_W > COORD_WIDTH) ? R_W : COORD_WIDTH) + 1;

	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);
	localparam logic signed [LS_W-1:0]   ROUND_HALF  = LS_W'(2 ** (TRIG_FRAC - 1));

	// Angle reduction limits in 1/64 degree.
	localparam logic signed [ANG_W-1:0] FULL_TURN    = ANG_W'(23040);
	localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(11520);
	localparam logic signed [ANG_W-1:0] NEG_HALF     = ANG_W'(-11520);
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(5760);
	localparam logic signed [ANG_W-1:0] NEG_QUARTER  = ANG_W'(-5760);

	// Arctangent of 2^-i in units of 2^-22 degree, rounded to nearest.
	localparam int ATAN_ENTRIES = 31;
	localparam logic signed [Z_W-1:0] ATAN_TAB [0:ATAN_ENTRIES-1] = '{
		Z_W'(188743680), Z_W'(111421900), Z_W'(58872272), Z_W'(29884485),
		Z_W'(15000234), Z_W'(7507429), Z_W'(3754631), Z_W'(1877430),
		Z_W'(938729), Z_W'(469366), Z_W'(234683), Z_W'(117342),
		Z_W'(58671), Z_W'(29335), Z_W'(14668), Z_W'(7334),
		Z_W'(3667), Z_W'(1833), Z_W'(917), Z_W'(458),
		Z_W'(229), Z_W'(115), Z_W'(57), Z_W'(29),
		Z_W'(14), Z_W'(7), Z_W'(4), Z_W'(2),
		Z_W'(1), Z_W'(0), Z_W'(0)
	};

	// Rotation plane codes.
	typedef enum logic [1:0] {
		MODE_YZ   = 2'd0,
		MODE_XZ   = 2'd1,
		MODE_XY   = 2'd2,
		MODE_PASS = 2'd3
	} mode_t;

	// CORDIC vector and angle accumulator.
	typedef struct packed {
		logic signed [TRIG_W-1:0] x;
		logic signed [TRIG_W-1:0] y;
		logic signed [Z_W-1:0]    z;
	} cord_t;

	// Word that travels alongside the CORDIC vector.
	typedef struct packed {
		mode_t                         mode;
		logic                          flip;
		logic signed [COORD_WIDTH-1:0] px;
		logic signed [COORD_WIDTH-1:0] py;
		logic signed [COORD_WIDTH-1:0] pz;
		logic signed [COORD_WIDTH-1:0] cx;
		logic signed [COORD_WIDTH-1:0] cy;
		logic signed [COORD_WIDTH-1:0] cz;
	} pay_t;

	// Finished result word.
	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] z;
		logic                          sat;
	} res_t;

endpackage
`default_nettype wire

/* rtl/plrot_cordic_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plrot_cordic_cell: one micro-rotation of the CORDIC chain
// Rotates the vector by plus or minus atan(2^-sh) toward a zero angle
// accumulator and hands the result, with its side word, to the next cell.
// ----------------------------------------------------------------------------
module plrot_cordic_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic [plrot_pkg::SH_W-1:0]    sh,
	input  wire logic signed [plrot_pkg::Z_W-1:0] atan,
	input  wire logic                          v_in,
	input  wire plrot_pkg::cord_t              d_in,
	input  wire plrot_pkg::pay_t               pay_in,
	output logic                               v_out,
	output plrot_pkg::cord_t                   d_out,
	output plrot_pkg::pay_t                    pay_out
);
	import plrot_pkg::*;

	logic signed [TRIG_W-1:0] xs;
	logic signed [TRIG_W-1:0] ys;
	cord_t                    nxt;

	// Shifted cross terms and the rotation direction from the angle sign.
	always_comb begin
		xs = d_in.x >>> sh;
		ys = d_in.y >>> sh;
		if (!d_in.z[Z_W-1]) begin
			nxt.x = d_in.x - ys;
			nxt.y = d_in.y + xs;
			nxt.z = d_in.z - atan;
		end else begin
			nxt.x = d_in.x + ys;
			nxt.y = d_in.y - xs;
			nxt.z = d_in.z + atan;
		end
	end

	// Valid bit of this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	// Vector and side word.
	always_ff @(posedge clk) begin
		if (en) begin
			d_out   <= nxt;
			pay_out <= pay_in;
		end
	end

endmodule
`default_nettype wire

/* rtl/plrot_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plrot_cordic: angle reduction and the unrolled CORDIC chain
// Folds the angle into [-90, 90] degrees, noting a half-turn flip, then runs
// it through a row of micro-rotation cells that yields cosine and sine.
// ----------------------------------------------------------------------------
module plrot_cordic (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire logic                                v_in,
	input  wire logic signed [plrot_pkg::ANG_IN_W-1:0] angle,
	input  wire plrot_pkg::pay_t                     pay_in,
	output logic                                     v_out,
	output plrot_pkg::cord_t                         d_out,
	output plrot_pkg::pay_t                          pay_out
);
	import plrot_pkg::*;

	logic signed [ANG_W-1:0] a0;
	logic signed [ANG_W-1:0] a1;
	logic signed [ANG_W-1:0] a2;
	logic                    flip;
	pay_t                    pay_fl;

	logic                    v_s1;
	cord_t                   d_s1;
	pay_t                    pay_s1;

	logic                    v_c   [0:CORDIC_STAGES];
	cord_t                   d_c   [0:CORDIC_STAGES];
	pay_t                    pay_c [0:CORDIC_STAGES];

	// Wrap into [-180, 180) and then into [-90, 90] with a flip flag.
	always_comb begin
		a0 = ANG_W'(angle);
		if (a0 >= HALF_TURN) begin
			a1 = a0 - FULL_TURN;
		end else if (a0 < NEG_HALF) begin
			a1 = a0 + FULL_TURN;
		end else begin
			a1 = a0;
		end
		if (a1 > QUARTER_TURN) begin
			a2   = a1 - HALF_TURN;
			flip = 1'b1;
		end else if (a1 < NEG_QUARTER) begin
			a2   = a1 + HALF_TURN;
			flip = 1'b1;
		end else begin
			a2   = a1;
			flip = 1'b0;
		end

		// The side word carries the flip to the rotation datapath.
		pay_fl      = pay_in;
		pay_fl.flip = flip;
	end

	// Front register: starting vector and reduced angle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1.x <= CORDIC_GAIN;
			d_s1.y <= '0;
			d_s1.z <= Z_W'(a2) <<< Z_SHIFT;
			pay_s1 <= pay_fl;
		end
	end

	assign v_c[0]   = v_s1;
	assign d_c[0]   = d_s1;
	assign pay_c[0] = pay_s1;

	// Row of micro-rotation cells, one per CORDIC iteration.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		plrot_cordic_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.sh      (SH_W'(i)),
			.atan    (ATAN_TAB[i]),
			.v_in    (v_c[i]),
			.d_in    (d_c[i]),
			.pay_in  (pay_c[i]),
			.v_out   (v_c[i+1]),
			.d_out   (d_c[i+1]),
			.pay_out (pay_c[i+1])
		);
	end

	assign v_out   = v_c[CORDIC_STAGES];
	assign d_out   = d_c[CORDIC_STAGES];
	assign pay_out = pay_c[CORDIC_STAGES];

endmodule
`default_nettype wire

/* rtl/plrot_mac.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plrot_mac: rotation of the centered coordinates and saturation
// Five stages: difference from the center, split partial products, product
// sums with rounding, carry merge, and the center add with clipping.
// ----------------------------------------------------------------------------
module plrot_mac (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              v_in,
	input  wire plrot_pkg::cord_t  d_in,
	input  wire plrot_pkg::pay_t   pay_in,
	output logic                   v_out,
	output plrot_pkg::res_t        res_out
);
	import plrot_pkg::*;

	localparam logic signed [V_W-1:0] CMAX =
		{{(V_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [V_W-1:0] CMIN =
		{{(V_W - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

	// Stage 1 inputs.
	logic signed [COORD_WIDTH-1:0] pa, pb;
	logic signed [COORD_WIDTH-1:0] ca, cb;
	logic signed [TRIG_W-1:0]      cs, sn;

	logic                          v_s1, v_s2, v_s3, v_s4;
	pay_t                          pay_s1, pay_s2, pay_s3, pay_s4;
	logic signed [TRIG_W-1:0]      cs_s1, sn_s1;
	logic signed [DIFF_W-1:0]      da_s1, db_s1;

	// Stage 2 operands.
	logic signed [EXT_W-1:0]       da_ext, db_ext;
	logic signed [HI_W-1:0]        da_hi, db_hi;
	logic signed [LO_W:0]          da_lo, db_lo;

	logic signed [HP_W-1:0]        ac_hi_s2, bs_hi_s2, as_hi_s2, bc_hi_s2;
	logic signed [LP_W-1:0]        ac_lo_s2, bs_lo_s2, as_lo_s2, bc_lo_s2;

	logic signed [HS_W-1:0]        hs_a_s3, hs_b_s3;
	logic signed [LS_W-1:0]        ls_a_s3, ls_b_s3;

	logic signed [T_W-1:0]         t_a_s4, t_b_s4;

	// Stage 5 logic.
	logic signed [COORD_WIDTH-1:0] ca4, cb4;
	logic signed [R_W-1:0]         ra, rb;
	logic signed [V_W-1:0]         va, vb;
	logic signed [COORD_WIDTH-1:0] qa, qb;
	logic                          sat_a, sat_b;
	res_t                          res_nxt;

	// Apply the half-turn flip and pick the plane's two coordinates.
	always_comb begin
		cs = pay_in.flip ? -d_in.x : d_in.x;
		sn = pay_in.flip ? -d_in.y : d_in.y;
		unique case (pay_in.mode)
			MODE_YZ: begin
				pa = pay_in.py; ca = pay_in.cy; pb = pay_in.pz; cb = pay_in.cz;
			end
			MODE_XZ: begin
				pa = pay_in.px; ca = pay_in.cx; pb = pay_in.pz; cb = pay_in.cz;
			end
			default: begin
				pa = pay_in.px; ca = pay_in.cx; pb = pay_in.py; cb = pay_in.cy;
			end
		endcase
	end

	// Split each difference into a signed high part and an unsigned low part.
	always_comb begin
		da_ext = EXT_W'(da_s1);
		db_ext = EXT_W'(db_s1);
		da_hi  = da_ext[EXT_W-1:LO_W];
		db_hi  = db_ext[EXT_W-1:LO_W];
		da_lo  = {1'b0, da_ext[LO_W-1:0]};
		db_lo  = {1'b0, db_ext[LO_W-1:0]};
	end

	// Valid bits of the five stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_out <= 1'b0;
		end else if (en) begin
			v_s1  <= v_in;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_out <= v_s4;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (en) begin
			// Differences from the center.
			cs_s1  <= cs;
			sn_s1  <= sn;
			da_s1  <= DIFF_W'(pa) - DIFF_W'(ca);
			db_s1  <= DIFF_W'(pb) - DIFF_W'(cb);
			pay_s1 <= pay_in;

			// Partial products.
			ac_hi_s2 <= HP_W'(da_hi) * HP_W'(cs_s1);
			bs_hi_s2 <= HP_W'(db_hi) * HP_W'(sn_s1);
			as_hi_s2 <= HP_W'(da_hi) * HP_W'(sn_s1);
			bc_hi_s2 <= HP_W'(db_hi) * HP_W'(cs_s1);
			ac_lo_s2 <= LP_W'(da_lo) * LP_W'(cs_s1);
			bs_lo_s2 <= LP_W'(db_lo) * LP_W'(sn_s1);
			as_lo_s2 <= LP_W'(da_lo) * LP_W'(sn_s1);
			bc_lo_s2 <= LP_W'(db_lo) * LP_W'(cs_s1);
			pay_s2   <= pay_s1;

			// First coordinate takes da*cos - db*sin, second da*sin + db*cos.
			hs_a_s3 <= HS_W'(ac_hi_s2) - HS_W'(bs_hi_s2);
			hs_b_s3 <= HS_W'(as_hi_s2) + HS_W'(bc_hi_s2);
			ls_a_s3 <= LS_W'(ac_lo_s2) - LS_W'(bs_lo_s2) + ROUND_HALF;
			ls_b_s3 <= LS_W'(as_lo_s2) + LS_W'(bc_lo_s2) + ROUND_HALF;
			pay_s3  <= pay_s2;

			// Merge the low-part carry into the high sum.
			t_a_s4 <= T_W'(hs_a_s3) + T_W'($signed(ls_a_s3[LS_W-1:LO_W]));
			t_b_s4 <= T_W'(hs_b_s3) + T_W'($signed(ls_b_s3[LS_W-1:LO_W]));
			pay_s4 <= pay_s3;

			res_out <= res_nxt;
		end
	end

	// Remove the trig scaling, add the center back and clip.
	always_comb begin
		unique case (pay_s4.mode)
			MODE_YZ: begin
				ca4 = pay_s4.cy; cb4 = pay_s4.cz;
			end
			MODE_XZ: begin
				ca4 = pay_s4.cx; cb4 = pay_s4.cz;
			end
			default: begin
				ca4 = pay_s4.cx; cb4 = pay_s4.cy;
			end
		endcase
		ra = $signed(t_a_s4[T_W-1:TRIG_FRAC-LO_W]);
		rb = $signed(t_b_s4[T_W-1:TRIG_FRAC-LO_W]);
		va = V_W'(ca4) + V_W'(ra);
		vb = V_W'(cb4) + V_W'(rb);
		sat_a = (va > CMAX) || (va < CMIN);
		sat_b = (vb > CMAX) || (vb < CMIN);
		qa = (va > CMAX) ? CMAX[COORD_WIDTH-1:0] :
		     (va < CMIN) ? CMIN[COORD_WIDTH-1:0] : va[COORD_WIDTH-1:0];
		qb = (vb > CMAX) ? CMAX[COORD_WIDTH-1:0] :
		     (vb < CMIN) ? CMIN[COORD_WIDTH-1:0] : vb[COORD_WIDTH-1:0];

		// Put the rotated pair back in place; the third coordinate passes.
		res_nxt.x   = pay_s4.px;
		res_nxt.y   = pay_s4.py;
		res_nxt.z   = pay_s4.pz;
		res_nxt.sat = sat_a | sat_b;
		unique case (pay_s4.mode)
			MODE_YZ: begin
				res_nxt.y = qa;
				res_nxt.z = qb;
			end
			MODE_XZ: begin
				res_nxt.x = qa;
				res_nxt.z = qb;
			end
			MODE_XY: begin
				res_nxt.x = qa;
				res_nxt.y = qb;
			end
			MODE_PASS: begin
				res_nxt.sat = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/plane_rotation_about_center.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plane_rotation_about_center: rotate a 3D point about a center in one plane
// Top level: CORDIC chain, rotation datapath and the output word register
// with a skid stage.
// ----------------------------------------------------------------------------
// The block takes one word per clock while in_ready is high and returns one
// word per word taken, in order. A word passes through one register for angle
// reduction, one per CORDIC cell (16 by default), five in the multiply and
// saturate datapath, and one in the output register. Throughput is one word
// per cycle while the skid stage is empty, set by the unrolled CORDIC cell
// row and the fully pipelined split multipliers. A stalled output word is
// held in the output register while one more word lands in the skid stage;
// input ready drops only once the skid stage is full. Mode 3 passes the point
// through unchanged with saturated low.
// ----------------------------------------------------------------------------
module plane_rotation_about_center (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [1:0]                             mode,
	input  wire logic signed [plrot_pkg::ANG_IN_W-1:0]  angle,
	input  wire logic signed [plrot_pkg::COORD_WIDTH-1:0] point_x,
	input  wire logic signed [plrot_pkg::COORD_WIDTH-1:0] point_y,
	input  wire logic signed [plrot_pkg::COORD_WIDTH-1:0] point_z,
	input  wire logic signed [plrot_pkg::COORD_WIDTH-1:0] center_x,
	input  wire logic signed [plrot_pkg::COORD_WIDTH-1:0] center_y,
	input  wire logic signed [plrot_pkg::COORD_WIDTH-1:0] center_z,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [plrot_pkg::COORD_WIDTH-1:0]    out_x,
	output logic signed [plrot_pkg::COORD_WIDTH-1:0]    out_y,
	output logic signed [plrot_pkg::COORD_WIDTH-1:0]    out_z,
	output logic                                        saturated
);
	import plrot_pkg::*;

	logic  adv;
	pay_t  pay_in;
	logic  cor_v;
	cord_t cor_d;
	pay_t  cor_pay;
	logic  res_v;
	res_t  res;

	logic  out_v_q;
	res_t  out_q;
	logic  skid_v_q;
	res_t  skid_q;
	logic  slot_free;
	logic  load_out_res;
	logic  load_out_skid;
	logic  load_skid;

	// The whole pipeline moves whenever the skid stage is empty.
	assign adv      = !skid_v_q;
	assign in_ready = adv;

	// Incoming word.
	always_comb begin
		pay_in.mode = mode_t'(mode);
		pay_in.flip = 1'b0;
		pay_in.px   = point_x;
		pay_in.py   = point_y;
		pay_in.pz   = point_z;
		pay_in.cx   = center_x;
		pay_in.cy   = center_y;
		pay_in.cz   = center_z;
	end

	plrot_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.v_in    (in_valid),
		.angle   (angle),
		.pay_in  (pay_in),
		.v_out   (cor_v),
		.d_out   (cor_d),
		.pay_out (cor_pay)
	);

	plrot_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.v_in    (cor_v),
		.d_in    (cor_d),
		.pay_in  (cor_pay),
		.v_out   (res_v),
		.res_out (res)
	);

	// Steering between the output register and the skid stage.
	always_comb begin
		slot_free     = !out_v_q || out_ready;
		load_out_skid = skid_v_q && out_ready;
		load_out_res  = !skid_v_q && res_v && slot_free;
		load_skid     = !skid_v_q && res_v && !slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (load_out_skid) begin
				skid_v_q <= 1'b0;
			end else if (load_skid) begin
				skid_v_q <= 1'b1;
			end
			if (load_out_skid || load_out_res) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out_skid) begin
			out_q <= skid_q;
		end else if (load_out_res) begin
			out_q <= res;
		end
		if (load_skid) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign out_x     = out_q.x;
	assign out_y     = out_q.y;
	assign out_z     = out_q.z;
	assign saturated = out_q.sat;

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for plane_rotation_about_center
// Words are sent through a valid/ready channel in random bursts while the
// result channel stalls on its own pattern. A software CORDIC and rotation
// predictor computes each expected result word at acceptance. The checker
// compares every returned word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import plrot_pkg::*;

	localparam int PIPE_LATENCY = 22;
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_WORDS = 1330;

	// Angle units are 1/64 degree; the CORDIC angle is in 2^-22 degree.
	localparam longint TURN_UNITS    = 23040;
	localparam longint HALF_UNITS    = 11520;
	localparam longint QUARTER_UNITS = 5760;
	localparam longint ROT_GAIN      = 652032874;
	localparam int     ROT_STAGES    = 16;

	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = 32'sh7fffffff;
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = 32'sh80000000;

	// One input word as the bench sees it.
	typedef struct packed {
		mode_t                         mode;
		logic signed [ANG_IN_W-1:0]    angle;
		logic signed [COORD_WIDTH-1:0] px;
		logic signed [COORD_WIDTH-1:0] py;
		logic signed [COORD_WIDTH-1:0] pz;
		logic signed [COORD_WIDTH-1:0] cx;
		logic signed [COORD_WIDTH-1:0] cy;
		logic signed [COORD_WIDTH-1:0] cz;
	} point_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = 2'd0;
	logic signed [ANG_IN_W-1:0] angle = '0;
	logic signed [COORD_WIDTH-1:0] point_x = '0;
	logic signed [COORD_WIDTH-1:0] point_y = '0;
	logic signed [COORD_WIDTH-1:0] point_z = '0;
	logic signed [COORD_WIDTH-1:0] center_x = '0;
	logic signed [COORD_WIDTH-1:0] center_y = '0;
	logic signed [COORD_WIDTH-1:0] center_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [COORD_WIDTH-1:0] out_x;
	logic signed [COORD_WIDTH-1:0] out_y;
	logic signed [COORD_WIDTH-1:0] out_z;
	logic saturated;

	// Arctangent of 2^-i in 2^-22 degree, rounded to nearest.
	longint arctan_lut [ROT_STAGES] = '{
		188743680, 111421900, 58872272, 29884485, 15000234, 7507429, 3754631,
		1877430, 938729, 469366, 234683, 117342, 58671, 29335, 14668, 7334
	};

	res_t expected_points [$];
	int   error_count = 0;
	int   burst_left = 0;
	int   idle_cycles = 0;
	int   rx_left = 0;
	int   rx_style = 0;

	plane_rotation_about_center dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.angle     (angle),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.center_x  (center_x),
		.center_y  (center_y),
		.center_z  (center_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.saturated (saturated)
	);

	// Free-running clock, 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Cosine and sine in Q2.30 from a rotation-mode CORDIC after folding the
	// angle into the right half plane.
	function automatic void cordic_trig(input logic signed [ANG_IN_W-1:0] ang,
			output longint cos_q, output longint sin_q);
		longint a, x, y, z, xs, ys;
		bit flip;
		a = ((longint'(ang) % TURN_UNITS) + TURN_UNITS) % TURN_UNITS;
		flip = 1'b0;
		if (a >= HALF_UNITS)
			a = a - TURN_UNITS;
		if (a > QUARTER_UNITS) begin
			a = a - HALF_UNITS;
			flip = 1'b1;
		end else if (a < -QUARTER_UNITS) begin
			a = a + HALF_UNITS;
			flip = 1'b1;
		end
		x = ROT_GAIN;
		y = 0;
		z = a * 65536;
		for (int i = 0; i < ROT_STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - arctan_lut[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + arctan_lut[i];
			end
		end
		cos_q = flip ? -x : x;
		sin_q = flip ? -y : y;
	endfunction

	// Rounded (p*c - q*s) / 2^30, kept exact in a wide accumulator.
	function automatic longint trig_combine(longint p, longint q, longint c, longint s);
		logic signed [127:0] wp, wq, wc, ws, acc;
		wp = p;
		wq = q;
		wc = c;
		ws = s;
		acc = wp * wc - wq * ws + (128'sd1 <<< 29);
		return longint'(acc >>> 30);
	endfunction

	// Clip to the signed coordinate range and flag any clipping.
	function automatic longint clip_coord(longint v, inout bit clipped);
		if (v > longint'(COORD_MAX)) begin
			clipped = 1'b1;
			return longint'(COORD_MAX);
		end
		if (v < longint'(COORD_MIN)) begin
			clipped = 1'b1;
			return longint'(COORD_MIN);
		end
		return v;
	endfunction

	// Expected result word for one input word.
	function automatic res_t rotate_point(point_word_t w);
		longint pt [3];
		longint ctr [3];
		longint rot [3];
		longint cos_q, sin_q, da, db;
		int ia, ib;
		bit clipped;
		res_t r;
		pt[0] = w.px;
		pt[1] = w.py;
		pt[2] = w.pz;
		ctr[0] = w.cx;
		ctr[1] = w.cy;
		ctr[2] = w.cz;
		rot = pt;
		clipped = 1'b0;
		if (w.mode != MODE_PASS) begin
			ia = (w.mode == MODE_YZ) ? 1 : 0;
			ib = (w.mode == MODE_XY) ? 1 : 2;
			cordic_trig(w.angle, cos_q, sin_q);
			da = pt[ia] - ctr[ia];
			db = pt[ib] - ctr[ib];
			rot[ia] = clip_coord(ctr[ia] + trig_combine(da, db, cos_q, sin_q), clipped);
			rot[ib] = clip_coord(ctr[ib] + trig_combine(da, db, sin_q, -cos_q), clipped);
		end
		r.x = rot[0][COORD_WIDTH-1:0];
		r.y = rot[1][COORD_WIDTH-1:0];
		r.z = rot[2][COORD_WIDTH-1:0];
		r.sat = clipped;
		return r;
	endfunction

	function automatic point_word_t make_word(mode_t m, int ang,
			logic signed [COORD_WIDTH-1:0] px, logic signed [COORD_WIDTH-1:0] py,
			logic signed [COORD_WIDTH-1:0] pz, logic signed [COORD_WIDTH-1:0] cx,
			logic signed [COORD_WIDTH-1:0] cy, logic signed [COORD_WIDTH-1:0] cz);
		point_word_t w;
		w.mode = m;
		w.angle = ang[ANG_IN_W-1:0];
		w.px = px;
		w.py = py;
		w.pz = pz;
		w.cx = cx;
		w.cy = cy;
		w.cz = cz;
		return w;
	endfunction

	// Coordinate drawn from a mix of full-range, small and extreme values.
	function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return $signed($urandom_range(0, 2097151)) - 1048576;
			7:          return COORD_MAX;
			8:          return COORD_MIN;
			default:    return $signed($urandom_range(0, 536870911)) - 268435456;
		endcase
	endfunction

	task automatic report_error(string msg);
		error_count++;
		if (error_count <= 10)
			$display("%s", msg);
	endtask

	// The sender idles between bursts of random length.
	task automatic pace_sender();
		int gap;
		if (burst_left != 0) begin
			burst_left = burst_left - 1;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
	endtask

	// Present one word, hold it until accepted, and record its prediction.
	task automatic send_word(point_word_t w);
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= w.mode;
		angle <= w.angle;
		point_x <= w.px;
		point_y <= w.py;
		point_z <= w.pz;
		center_x <= w.cx;
		center_y <= w.cy;
		center_z <= w.cz;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_points.push_back(rotate_point(w));
		pace_sender();
	endtask

	// Each plane code, the pass-through code among them.
	task automatic test_planes();
		send_word(make_word(MODE_YZ, 5760, 32'sh00030000, 32'sh00010000,
			32'sh00020000, 32'sh00001000, 32'sh00002000, 32'sh00003000));
		send_word(make_word(MODE_XZ, 2880, 32'shfffe0000, 32'sh00050000,
			32'sh00040000, 32'sh00010000, 32'sh00010000, 32'shffff0000));
		send_word(make_word(MODE_XY, -1920, 32'sh00100000, 32'shfff00000,
			32'sh12345678, 32'sh00000000, 32'sh00000000, 32'sh7eadbeef));
		send_word(make_word(MODE_PASS, 5760, COORD_MAX, COORD_MIN,
			32'sh5a5a5a5a, COORD_MIN, COORD_MAX, 32'sha5a5a5a5));
	endtask

	// Quadrant folding and wrap at a full turn in both directions.
	task automatic test_angle_reduction();
		int angles [12] = '{0, 1, 5760, -5760, 5761, -5761, 11519, 11520, -11520,
			17280, 23040, -23040};
		foreach (angles[i])
			send_word(make_word(mode_t'(i % 3), angles[i], 32'sh00050000,
				32'shfffd0000, 32'sh00070000, 32'sh00008000, 32'shffff8000,
				32'sh00010000));
	endtask

	// Rotated coordinates that clip, high and low on x in the XY plane and high in the YZ and XZ planes.
	task automatic test_saturation();
		send_word(make_word(MODE_XY, 11520, COORD_MIN, 32'sh0, 32'sh0,
			32'sh40000000, 32'sh0, 32'sh0));
		send_word(make_word(MODE_XY, -11520, COORD_MAX, 32'sh0, 32'sh0,
			32'shc0000000, 32'sh0, 32'sh0));
		send_word(make_word(MODE_YZ, 5760, 32'sh0, COORD_MAX, COORD_MIN,
			32'sh0, 32'shc0000000, 32'sh40000000));
		send_word(make_word(MODE_XZ, -5760, COORD_MIN, 32'sh0, COORD_MAX,
			32'sh40000000, 32'sh0, 32'shc0000000));
	endtask

	// Coordinates at the ends of their range.
	task automatic test_extremes();
		send_word(make_word(MODE_XY, 0, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX));
		send_word(make_word(MODE_YZ, 23040, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN));
		send_word(make_word(MODE_XZ, 7777, COORD_MAX, COORD_MIN, COORD_MAX,
			COORD_MIN, COORD_MAX, COORD_MIN));
		send_word(make_word(MODE_PASS, -23040, COORD_MIN, COORD_MAX, COORD_MIN,
			COORD_MAX, COORD_MIN, COORD_MAX));
	endtask

	// Random words: mostly rotations, a few pass-through, angles near the
	// quadrant boundaries part of the time.
	task automatic test_random(int count);
		point_word_t w;
		int ang;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 15) == 0)
				w.mode = MODE_PASS;
			else
				w.mode = mode_t'(2'($urandom_range(0, 2)));
			if ($urandom_range(0, 3) == 0) begin
				ang = ($signed($urandom_range(0, 8)) - 4) * 5760
					+ $signed($urandom_range(0, 2)) - 1;
				if (ang > 23040)
					ang = 23040;
				if (ang < -23040)
					ang = -23040;
			end else begin
				ang = $signed($urandom_range(0, 46080)) - 23040;
			end
			w.angle = ang[ANG_IN_W-1:0];
			w.cx = rand_coord();
			w.cy = rand_coord();
			w.cz = rand_coord();
			// Points close to the center some of the time, independent otherwise.
			if ($urandom_range(0, 3) == 0) begin
				w.px = w.cx + ($signed($urandom_range(0, 65535)) - 32768);
				w.py = w.cy + ($signed($urandom_range(0, 65535)) - 32768);
				w.pz = w.cz + ($signed($urandom_range(0, 65535)) - 32768);
			end else begin
				w.px = rand_coord();
				w.py = rand_coord();
				w.pz = rand_coord();
			end
			send_word(w);
		end
	endtask

	// The receiver switches between always ready, random stalls and a
	// periodic pattern with long stalls.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_style <= $urandom_range(0, 2);
			rx_left <= $urandom_range(20, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_style)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= (rx_left % 16) < 5;
		endcase
	end

	// Compare each returned word with the oldest prediction.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				report_error($sformatf("unexpected result word: x=%h y=%h z=%h sat=%b",
					out_x, out_y, out_z, saturated));
			end else begin
				want = expected_points.pop_front();
				if (out_x !== want.x)
					report_error($sformatf("out_x mismatch: expected %h got %h", want.x, out_x));
				if (out_y !== want.y)
					report_error($sformatf("out_y mismatch: expected %h got %h", want.y, out_y));
				if (out_z !== want.z)
					report_error($sformatf("out_z mismatch: expected %h got %h", want.z, out_z));
				if (saturated !== want.sat)
					report_error($sformatf("saturated mismatch: expected %b got %b",
						want.sat, saturated));
			end
		end
	end

	// Watchdog: too many cycles without a word moving on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Test sequence.
	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		test_planes();
		test_angle_reduction();
		test_saturation();
		test_extremes();
		test_random(RANDOM_WORDS);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/plrot_pkg.sv
rtl/plrot_cordic_cell.sv
rtl/plrot_cordic.sv
rtl/plrot_mac.sv
rtl/plane_rotation_about_center.sv
test/tb_top.sv
